// ----- design/pcd_pkg.sv -----
package pcd_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Field widths
  localparam int ID_W = 16;
  localparam int TIME_W = 32;
  localparam int CD_W = 20;
  localparam int LIM_W = CD_W + 1;
  localparam int ENT_W = 6;

  localparam logic [CD_W-1:0] COOLDOWN_RESET = CD_W'(30000);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OUT_IGNORED  = 2'd0,
    OUT_BLOCKED  = 2'd1,
    OUT_RECORDED = 2'd2,
    OUT_FULL     = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CHECK,
    B_COMPACT,
    B_FINISH
  } back_state_t;

  // One queued event
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] now;
    logic              candidate;
  } item_t;

  // One table entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  // Cooldown settings seen by the back end
  typedef struct packed {
    logic [CD_W-1:0]  cooldown;
    logic [LIM_W-1:0] limit2;
  } cfg_t;

endpackage

// ----- design/per_id_cooldown_table.sv -----
// Per-id cooldown table. Pulse start while busy is low to transfer one
// event; busy rises only when the two-entry event queue is full. Every
// event yields exactly one result, shown for one cycle with done high; the
// receiver cannot stall, so it must take each result as it comes. An event
// that is not a traveler entering the close zone is popped and answered by
// the back end from its idle state. A qualifying event streams the table, of
// up to 32 entries, through a memory with one read and one write port, one
// entry per cycle: a cooldown check pass, then a compaction pass, then a
// final update; the check pass ends early when it finds a blocking entry.
// Write cfg_wdata with cfg_we only while no event is pending.
module per_id_cooldown_table
  import pcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [ID_W-1:0]   device_id,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              is_traveler,
  input  logic              entered_close,
  input  logic              cfg_we,
  input  logic [CD_W-1:0]   cfg_wdata,
  output logic              done,
  output logic [1:0]        outcome,
  output logic [CD_W-1:0]   remaining_ms,
  output logic [ENT_W-1:0]  entries_in_use
);

  cfg_t             cfg;
  item_t            push_item;
  item_t            head_item;
  logic             push;
  logic             pop;
  logic             q_valid;
  logic             q_full;
  outcome_t         res_outcome;
  logic [CNT_W-1:0] count;

  pcd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .device_id     (device_id),
    .now_ms        (now_ms),
    .is_traveler   (is_traveler),
    .entered_close (entered_close),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .q_full        (q_full),
    .busy          (busy),
    .push          (push),
    .push_item     (push_item),
    .cfg           (cfg)
  );

  pcd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .not_empty (q_valid),
    .full      (q_full)
  );

  pcd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (head_item),
    .pop           (pop),
    .res_valid     (done),
    .res_outcome   (res_outcome),
    .res_remaining (remaining_ms),
    .res_entries   (entries_in_use),
    .count         (count)
  );

  assign outcome = res_outcome;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_ENTRIES))
    else $error("table count above capacity");

  a_blocked_rem: assert property (@(posedge clk) disable iff (rst)
    (done && outcome == OUT_BLOCKED) |->
      (remaining_ms != '0 && remaining_ms <= cfg.cooldown))
    else $error("blocked result with bad remaining time");

  a_other_rem: assert property (@(posedge clk) disable iff (rst)
    (done && outcome != OUT_BLOCKED) |-> remaining_ms == '0)
    else $error("remaining time on a result that was not blocked");

  a_entries: assert property (@(posedge clk) disable iff (rst)
    done |-> entries_in_use == ENT_W'(count))
    else $error("reported entry count differs from table count");
`endif

endmodule

// ----- design/pcd_front.sv -----
module pcd_front
  import pcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ID_W-1:0]   device_id,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              is_traveler,
  input  logic              entered_close,
  input  logic              cfg_we,
  input  logic [CD_W-1:0]   cfg_wdata,
  input  logic              q_full,
  output logic              busy,
  output logic              push,
  output item_t             push_item,
  output cfg_t              cfg
);

  logic [CD_W-1:0]  cooldown;
  logic [LIM_W-1:0] limit2;

  // Cooldown register, with the doubled limit kept alongside
  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown <= COOLDOWN_RESET;
      limit2   <= {COOLDOWN_RESET, 1'b0};
    end else if (cfg_we) begin
      cooldown <= cfg_wdata;
      limit2   <= {cfg_wdata, 1'b0};
    end
  end

  assign cfg.cooldown = cooldown;
  assign cfg.limit2   = limit2;

  // Accept and classify
  assign busy = q_full;
  assign push = start && !q_full;
  assign push_item.id        = device_id;
  assign push_item.now       = now_ms;
  assign push_item.candidate = is_traveler && entered_close;

endmodule

// ----- design/pcd_fifo.sv -----
module pcd_fifo
  import pcd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head_item,
  output logic  not_empty,
  output logic  full
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return QPTR_W'(p + 1'b1);
  endfunction

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= QCNT_W'(fill + 1'b1);
      end else if (pop && !push) begin
        fill <= QCNT_W'(fill - 1'b1);
      end
    end
  end

  assign head_item = slots[rd_ptr];
  assign not_empty = (fill != '0);
  assign full      = (fill == QCNT_W'(QUEUE_DEPTH));

endmodule

// ----- design/pcd_back.sv -----
module pcd_back
  import pcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             pop,
  output logic             res_valid,
  output outcome_t         res_outcome,
  output logic [CD_W-1:0]  res_remaining,
  output logic [ENT_W-1:0] res_entries,
  output logic [CNT_W-1:0] count
);

  back_state_t state, state_next;

  logic [CNT_W-1:0]  issue_cnt, issue_cnt_next;
  logic              pend, pend_next;
  logic [CNT_W-1:0]  wr_cnt, wr_cnt_next;
  logic              found, found_next;
  logic [CNT_W-1:0]  count_next;
  logic [ID_W-1:0]   cur_id, cur_id_next;
  logic [TIME_W-1:0] cur_now, cur_now_next;

  logic              res_valid_next;
  outcome_t          res_outcome_next;
  logic [CD_W-1:0]   res_remaining_next;
  logic [ENT_W-1:0]  res_entries_next;

  // Table memory, one read and one write port
  entry_t            mem [TABLE_ENTRIES];
  entry_t            rd_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  logic [TIME_W-1:0] age;
  logic              id_hit;
  logic              young;
  logic              keep;
  logic              issue_more;
  logic              scan_done;
  logic              has_room;
  logic [CNT_W-1:0]  fin_count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Evaluate the entry returned by the memory
  assign age        = cur_now - rd_data.stamp;
  assign id_hit     = (rd_data.id == cur_id);
  assign young      = (age < TIME_W'(cfg.cooldown));
  assign keep       = (age < TIME_W'(cfg.limit2));
  assign issue_more = (issue_cnt < count);
  assign scan_done  = !pend && !issue_more;
  assign has_room   = (wr_cnt < CNT_W'(TABLE_ENTRIES));
  assign fin_count  = (found || !has_room) ? wr_cnt : CNT_W'(wr_cnt + 1'b1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_valid && q_item.candidate) begin
          state_next = B_CHECK;
        end
      end
      B_CHECK: begin
        if (pend && id_hit && young) begin
          state_next = B_IDLE;
        end else if (scan_done) begin
          state_next = B_COMPACT;
        end
      end
      B_COMPACT: begin
        if (scan_done) begin
          state_next = B_FINISH;
        end
      end
      B_FINISH: begin
        state_next = B_IDLE;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    issue_cnt_next     = issue_cnt;
    pend_next          = 1'b0;
    wr_cnt_next        = wr_cnt;
    found_next         = found;
    count_next         = count;
    cur_id_next        = cur_id;
    cur_now_next       = cur_now;
    res_valid_next     = 1'b0;
    res_outcome_next   = res_outcome;
    res_remaining_next = res_remaining;
    res_entries_next   = res_entries;
    pop                = 1'b0;
    rd_en              = 1'b0;
    rd_addr            = issue_cnt[IDX_W-1:0];
    wr_en              = 1'b0;
    wr_addr            = wr_cnt[IDX_W-1:0];
    wr_data.id         = cur_id;
    wr_data.stamp      = cur_now;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (!q_item.candidate) begin
            res_valid_next     = 1'b1;
            res_outcome_next   = OUT_IGNORED;
            res_remaining_next = '0;
            res_entries_next   = ENT_W'(count);
          end else begin
            cur_id_next    = q_item.id;
            cur_now_next   = q_item.now;
            issue_cnt_next = '0;
          end
        end
      end
      B_CHECK: begin
        // Stream reads, look for a live entry of the same id
        if (issue_more) begin
          rd_en          = 1'b1;
          issue_cnt_next = CNT_W'(issue_cnt + 1'b1);
          pend_next      = 1'b1;
        end
        if (pend && id_hit && young) begin
          res_valid_next     = 1'b1;
          res_outcome_next   = OUT_BLOCKED;
          res_remaining_next = cfg.cooldown - age[CD_W-1:0];
          res_entries_next   = ENT_W'(count);
        end else if (scan_done) begin
          issue_cnt_next = '0;
          wr_cnt_next    = '0;
          found_next     = 1'b0;
        end
      end
      B_COMPACT: begin
        // Keep fresh entries in order, refresh the matching one
        if (issue_more) begin
          rd_en          = 1'b1;
          issue_cnt_next = CNT_W'(issue_cnt + 1'b1);
          pend_next      = 1'b1;
        end
        if (pend && keep) begin
          wr_en         = 1'b1;
          wr_data.id    = rd_data.id;
          wr_data.stamp = (id_hit && !found) ? cur_now : rd_data.stamp;
          wr_cnt_next   = CNT_W'(wr_cnt + 1'b1);
          if (id_hit) begin
            found_next = 1'b1;
          end
        end
      end
      B_FINISH: begin
        // Append when the id is new and there is room
        if (!found && has_room) begin
          wr_en = 1'b1;
        end
        count_next         = fin_count;
        res_valid_next     = 1'b1;
        res_outcome_next   = (found || has_room) ? OUT_RECORDED : OUT_FULL;
        res_remaining_next = '0;
        res_entries_next   = ENT_W'(fin_count);
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      pend      <= 1'b0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pend      <= pend_next;
      count     <= count_next;
      res_valid <= res_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    issue_cnt     <= issue_cnt_next;
    wr_cnt        <= wr_cnt_next;
    found         <= found_next;
    cur_id        <= cur_id_next;
    cur_now       <= cur_now_next;
    res_outcome   <= res_outcome_next;
    res_remaining <= res_remaining_next;
    res_entries   <= res_entries_next;
  end

endmodule
